>>> sv/text_stream_line_number_escape_assert.svh
// Assertion macros for the line numbering and escape filter.
// Used by the top level only; no other dependencies.
`ifndef TEXT_STREAM_LINE_NUMBER_ESCAPE_ASSERT_SVH
`define TEXT_STREAM_LINE_NUMBER_ESCAPE_ASSERT_SVH
`ifndef SYNTH
`define TSLNE_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define TSLNE_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define TSLNE_ASSERT(lbl, clk, rstn, prop, msg)
`define TSLNE_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

>>> sv/tslne_pkg.sv
// Shared types, constants and character codes of the line numbering filter.
// No dependencies.
`default_nettype none
package tslne_pkg;

    localparam int NUMBER_DIGITS = 6;
    localparam int NUM_COLS      = NUMBER_DIGITS + 1;
    localparam int CNT_W         = $clog2(NUMBER_DIGITS + 5);
    localparam int FIFO_DEPTH    = 2;
    localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);
    localparam int CFG_IDX_W     = 3;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CTRL_OFS  = 8'h40;

    typedef logic [NUMBER_DIGITS-1:0][3:0] t_bcd;
    localparam t_bcd BCD_ONE = t_bcd'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_ALL      = 3'd0,
        CFG_NUM_NONBLANK = 3'd1,
        CFG_SHOW_ENDS    = 3'd2,
        CFG_SQUEEZE      = 3'd3,
        CFG_SHOW_TABS    = 3'd4,
        CFG_SHOW_NONPRT  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic num_all;
        logic num_nonblank;
        logic show_ends;
        logic squeeze;
        logic show_tabs;
        logic show_nonprt;
    } t_cfg;

    // How the back end renders the character of one item
    typedef enum logic [1:0] {
        K_PLAIN,
        K_LINE_END,
        K_CARET,
        K_META
    } t_kind;

    typedef struct packed {
        logic       has_num;
        t_bcd       bcd;
        t_kind      kind;
        logic [7:0] chr;
    } t_desc;

    typedef struct packed {
        logic  valid;
        t_desc desc;
    } t_q_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage
`default_nettype wire

>>> sv/tslne_in_if.sv
// Input text channel: one raw byte and a file start flag per beat.
// No dependencies.
`default_nettype none
interface tslne_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       file_start;

    modport source (output valid, output text_byte, output file_start, input ready);
    modport sink   (input valid, input text_byte, input file_start, output ready);
endinterface
`default_nettype wire

>>> sv/tslne_out_if.sv
// Output text channel: one formatted byte and an end-of-run flag per beat.
// No dependencies.
`default_nettype none
interface tslne_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;

    modport source (output valid, output out_byte, output run_last, input ready);
    modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface
`default_nettype wire

>>> sv/tslne_cfg_if.sv
// Configuration write channel: register index and one data bit per beat.
// Depends on tslne_pkg for the index width.
`default_nettype none
interface tslne_cfg_if;
    import tslne_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic                 data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> sv/tslne_front.sv
// Front end: accepts text bytes, tracks line state and numbering, and
// queues one render descriptor per unsqueezed byte. Depends on tslne_pkg, tslne_in_if.
`default_nettype none
module tslne_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tslne_pkg::t_cfg   i_cfg_regs,
    input  wire tslne_pkg::t_q_stat i_q_stat,
    tslne_in_if.sink               i_in,
    output tslne_pkg::t_q_push     o_push
);
    import tslne_pkg::*;

    logic       r_pwn, n_pwn;
    logic [1:0] r_br, n_br;
    t_bcd       r_bcd, n_bcd;

    logic       accept;
    logic       pwn;
    logic [1:0] br0;
    t_bcd       bcd0;
    logic       nl;
    logic       squeezed;
    logic       numbered;
    t_desc      desc;

    // Saturating BCD increment: all nines hold
    function automatic t_bcd bcd_inc(input t_bcd v);
        t_bcd r;
        logic carry;
        logic all9;
        r     = v;
        carry = 1'b1;
        all9  = 1'b1;
        for (int k = 0; k < NUMBER_DIGITS; k++) begin
            if (v[k] != 4'd9) all9 = 1'b0;
            if (carry) begin
                if (v[k] == 4'd9) begin
                    r[k] = 4'd0;
                end else begin
                    r[k]  = v[k] + 4'd1;
                    carry = 1'b0;
                end
            end
        end
        return all9 ? v : r;
    endfunction

    assign i_in.ready = !i_q_stat.full;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        pwn  = i_in.file_start | r_pwn;
        br0  = i_in.file_start ? 2'd0 : r_br;
        bcd0 = i_in.file_start ? BCD_ONE : r_bcd;
        nl   = (i_in.text_byte == CH_LF);

        if (pwn && nl) begin
            n_br = (br0 == 2'd3) ? 2'd3 : br0 + 2'd1;
        end else begin
            n_br = 2'd0;
        end

        squeezed = i_cfg_regs.squeeze && (n_br > 2'd1);
        numbered = pwn && (i_cfg_regs.num_all || i_cfg_regs.num_nonblank)
                   && !(i_cfg_regs.num_nonblank && (n_br != 2'd0));
        n_bcd    = (numbered && !squeezed) ? bcd_inc(bcd0) : bcd0;
        n_pwn    = nl;

        desc.has_num = numbered;
        desc.bcd     = bcd0;
        desc.kind    = K_PLAIN;
        desc.chr     = i_in.text_byte;
        if (nl) begin
            desc.kind = i_cfg_regs.show_ends ? K_LINE_END : K_PLAIN;
        end else if (i_in.text_byte == CH_TAB) begin
            if (i_cfg_regs.show_tabs) begin
                desc.kind = K_CARET;
                desc.chr  = CH_I;
            end
        end else if (i_cfg_regs.show_nonprt) begin
            if (i_in.text_byte inside {[8'h00:8'h1F]}) begin
                desc.kind = K_CARET;
                desc.chr  = i_in.text_byte + CTRL_OFS;
            end else if (i_in.text_byte == CH_DEL) begin
                desc.kind = K_CARET;
                desc.chr  = CH_QMARK;
            end else if (i_in.text_byte inside {[8'h80:8'h9F]}) begin
                desc.kind = K_META;
                desc.chr  = i_in.text_byte - CTRL_OFS;
            end
        end
    end

    assign o_push.valid = accept && !squeezed;
    assign o_push.desc  = desc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwn <= 1'b1;
            r_br  <= 2'd0;
            r_bcd <= BCD_ONE;
        end else if (accept) begin
            r_pwn <= n_pwn;
            r_br  <= n_br;
            r_bcd <= n_bcd;
        end
    end

endmodule
`default_nettype wire

>>> sv/tslne_fifo.sv
// Short descriptor queue between front and back end.
// Depends on tslne_pkg.
`default_nettype none
module tslne_fifo (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tslne_pkg::t_q_push i_push,
    input  wire logic               i_pop,
    output tslne_pkg::t_desc        o_head,
    output tslne_pkg::t_q_stat      o_stat
);
    import tslne_pkg::*;

    t_desc                 r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr, n_wr;
    logic [FIFO_PTR_W-1:0] r_rd, n_rd;
    logic [FIFO_CNT_W-1:0] r_cnt, n_cnt;
    logic                  do_push;
    logic                  do_pop;

    assign o_stat.full  = (r_cnt == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_head       = r_mem[r_rd];

    assign do_push = i_push.valid && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_push.desc;
    end

endmodule
`default_nettype wire

>>> sv/tslne_back.sv
// Back end: expands the head descriptor into output bytes, one beat a cycle
// unless stalled, through an output register. Depends on tslne_pkg, tslne_out_if.
`default_nettype none
module tslne_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tslne_pkg::t_desc   i_head,
    input  wire tslne_pkg::t_q_stat i_q_stat,
    output logic                    o_pop,
    tslne_out_if.source             o_out
);
    import tslne_pkg::*;

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_started, n_started;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_last;

    logic             advance;
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] prelen;
    logic             in_num;
    logic [3:0]       digit;
    logic             is_units;
    logic             start_now;
    logic [7:0]       nxt_byte;
    logic             nxt_last;

    assign advance = !i_q_stat.empty && (!r_out_valid || o_out.ready);

    always_comb begin
        in_num = i_head.has_num && (r_cnt < CNT_W'(NUM_COLS));
        pos    = i_head.has_num ? r_cnt - CNT_W'(NUM_COLS) : r_cnt;

        digit = 4'd0;
        for (int k = 0; k < NUMBER_DIGITS; k++) begin
            if (r_cnt == CNT_W'(NUMBER_DIGITS - 1 - k)) digit = i_head.bcd[k];
        end
        is_units  = (r_cnt == CNT_W'(NUMBER_DIGITS - 1));
        start_now = r_started || (digit != 4'd0) || is_units;

        case (i_head.kind)
            K_PLAIN:    prelen = CNT_W'(0);
            K_LINE_END: prelen = CNT_W'(1);
            K_CARET:    prelen = CNT_W'(1);
            K_META:     prelen = CNT_W'(3);
            default:    prelen = CNT_W'(0);
        endcase

        nxt_last  = 1'b0;
        n_started = r_started;
        if (in_num) begin
            if (r_cnt == CNT_W'(NUMBER_DIGITS)) begin
                nxt_byte = CH_TAB;
            end else begin
                // blank leading zeros until the first significant digit
                nxt_byte  = start_now ? (CH_ZERO | {4'h0, digit}) : CH_SPACE;
                n_started = start_now;
            end
        end else if (pos == prelen) begin
            nxt_byte = i_head.chr;
            nxt_last = 1'b1;
        end else begin
            case (i_head.kind)
                K_LINE_END: nxt_byte = CH_DOLLAR;
                K_CARET:    nxt_byte = CH_CARET;
                K_META: begin
                    if (pos == CNT_W'(0)) begin
                        nxt_byte = CH_M;
                    end else if (pos == CNT_W'(1)) begin
                        nxt_byte = CH_DASH;
                    end else begin
                        nxt_byte = CH_CARET;
                    end
                end
                default:    nxt_byte = i_head.chr;
            endcase
        end

        if (nxt_last) begin
            n_cnt     = '0;
            n_started = 1'b0;
        end else begin
            n_cnt = r_cnt + 1'b1;
        end
    end

    assign o_pop = advance && nxt_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_cnt     <= n_cnt;
                r_started <= n_started;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_byte <= nxt_byte;
            r_out_last <= nxt_last;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out_byte;
    assign o_out.run_last = r_out_last;

endmodule
`default_nettype wire

>>> sv/text_stream_line_number_escape.sv
// Top level of the line numbering and escape filter: configuration
// registers, front end, descriptor queue and back end. Depends on tslne_pkg.
//
// One text byte is accepted per cycle while the back end keeps up. Each
// accepted byte yields a run of 1 to NUMBER_DIGITS+5 output beats (11 with
// six digits): an optional right-justified number and tab, an optional
// escape prefix of up to three bytes, then the character; run_last marks the
// final beat. The back end emits one beat a cycle through its output
// register while the sink is ready, and a squeezed newline is accepted but
// yields no output. A two-entry queue between front and back end lets the
// input keep flowing while a run drains.
`default_nettype none
`include "text_stream_line_number_escape_assert.svh"
module text_stream_line_number_escape (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tslne_cfg_if.sink i_cfg,
    tslne_in_if.sink  i_in,
    tslne_out_if.source o_out
);
    import tslne_pkg::*;

    t_cfg    r_cfg;
    t_q_push push;
    t_q_stat q_stat;
    t_desc   head;
    logic    pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_NUM_ALL:      r_cfg.num_all      <= i_cfg.data;
                CFG_NUM_NONBLANK: r_cfg.num_nonblank <= i_cfg.data;
                CFG_SHOW_ENDS:    r_cfg.show_ends    <= i_cfg.data;
                CFG_SQUEEZE:      r_cfg.squeeze      <= i_cfg.data;
                CFG_SHOW_TABS:    r_cfg.show_tabs    <= i_cfg.data;
                CFG_SHOW_NONPRT:  r_cfg.show_nonprt  <= i_cfg.data;
                default:          ;
            endcase
        end
    end

    tslne_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_regs (r_cfg),
        .i_q_stat   (q_stat),
        .i_in       (i_in),
        .o_push     (push)
    );

    tslne_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    tslne_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_out    (o_out)
    );

    `TSLNE_ASSERT_NEVER(a_no_push_full, i_clk, i_rst_n, push.valid && q_stat.full, "push into full queue")
    `TSLNE_ASSERT_NEVER(a_no_pop_empty, i_clk, i_rst_n, pop && q_stat.empty, "pop from empty queue")
    `TSLNE_ASSERT(a_push_lands, i_clk, i_rst_n, push.valid |=> !q_stat.empty, "pushed item lost")
    `TSLNE_ASSERT(a_run_gapless, i_clk, i_rst_n, (o_out.valid && o_out.ready && !o_out.run_last) |=> o_out.valid, "gap inside run")

endmodule
`default_nettype wire
